### src/iira_pkg.sv
// Package for the indexed insert/remove array.
// Holds request, status and cell-operation codes and the control struct broadcast
// along the row of cells. No dependencies.
package iira_pkg;

	// Index width: covers positions and counts up to the largest supported depth (1024)
	localparam int IDX_BITS = 11;

	typedef enum logic [2:0] {
		CMD_PUSH   = 3'd0,
		CMD_INSERT = 3'd1,
		CMD_REMOVE = 3'd2,
		CMD_POP    = 3'd3,
		CMD_READ   = 3'd4,
		CMD_WRITE  = 3'd5,
		CMD_CLEAR  = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_CLEAR,
		CELL_PUT,
		CELL_OPEN,
		CELL_CLOSE
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic [IDX_BITS-1:0] lo;
		logic [IDX_BITS-1:0] hi;
	} cell_ctrl_t;

endpackage

### src/iira_cell.sv
// One storage cell of the array row; keeps its word or takes its next word from the new value,
// its left or right neighbor, or zero. Depends on iira_pkg.
module iira_cell #(
	parameter int WORD_BITS = 32,
	parameter int INDEX     = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  iira_pkg::cell_ctrl_t ctrl,
	input  logic [WORD_BITS-1:0] new_word,
	input  logic [WORD_BITS-1:0] left_word,
	input  logic [WORD_BITS-1:0] right_word,
	output logic [WORD_BITS-1:0] word
);

	localparam logic [iira_pkg::IDX_BITS-1:0] MY_IDX = iira_pkg::IDX_BITS'(INDEX);

	logic [WORD_BITS-1:0] word_q;
	logic [WORD_BITS-1:0] word_d;
	logic                 at_lo;
	logic                 at_hi;
	logic                 above_lo;
	logic                 below_hi;

	assign at_lo    = (MY_IDX == ctrl.lo);
	assign at_hi    = (MY_IDX == ctrl.hi);
	assign above_lo = (MY_IDX > ctrl.lo);
	assign below_hi = (MY_IDX < ctrl.hi);

	always_comb begin
		word_d = word_q;
		case (ctrl.op)
			iira_pkg::CELL_HOLD: begin
				word_d = word_q;
			end
			iira_pkg::CELL_CLEAR: begin
				word_d = '0;
			end
			iira_pkg::CELL_PUT: begin
				if (at_lo) word_d = new_word;
			end
			// insert: the cell at the index takes the new word; cells above it up to the first free cell take the left neighbor
			iira_pkg::CELL_OPEN: begin
				if (at_lo) word_d = new_word;
				else if (above_lo && (below_hi || at_hi)) word_d = left_word;
			end
			// remove: close the gap, zero the freed top cell
			iira_pkg::CELL_CLOSE: begin
				if (at_hi) word_d = '0;
				else if ((above_lo || at_lo) && below_hi) word_d = right_word;
			end
			default: begin
				word_d = word_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else begin
			word_q <= word_d;
		end
	end

	assign word = word_q;

endmodule

### src/indexed_insert_remove_array.sv
// Top level of the indexed insert/remove array: request decode, fill count,
// result register and the row of iira_cell instances. Depends on iira_pkg, iira_cell.
//
//   channel  | handshake            | payload
//   request  | in_valid / in_ready  | cmd, position, value
//   result   | out_valid / out_ready| read_data, status, fill, is_empty
//
// One request per cycle while no result is stalled: every cell shifts in parallel, so a request updates
// the row in the cycle it is accepted and its result is registered for the next.
// The read path is one DEPTH-way select over the cells (read index or top).
// in_ready is low only while a result waits and out_ready is low.
// Reset zeroes every cell and the fill count; no result is pending after reset.
module indexed_insert_remove_array #(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         cmd,
	input  logic [4:0]         position,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] read_data,
	output logic [1:0]         status,
	output logic [4:0]         fill,
	output logic               is_empty
);

	localparam int UW  = $clog2(DEPTH + 1);
	localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW  = iira_pkg::IDX_BITS;
	localparam logic [IW-1:0] DEPTH_X = IW'(DEPTH);

	logic [UW-1:0]          used_q;
	logic [UW-1:0]          used_d;
	logic                   out_valid_q;
	logic signed [31:0]     read_data_q;
	logic [1:0]             status_q;
	logic [4:0]             fill_q;
	logic                   is_empty_q;

	logic                   accept;
	logic [IW-1:0]          pos_x;
	logic [IW-1:0]          used_x;
	logic [IW-1:0]          top_x;
	logic [WORD_BITS-1:0]   new_word;
	iira_pkg::cell_ctrl_t   ctrl;
	logic [1:0]             st;
	logic                   rd_en;
	logic [IW-1:0]          rd_addr;
	logic [WORD_BITS-1:0]   rd_word;
	logic signed [31:0]     rd_out;
	logic [WORD_BITS-1:0]   cell_word [DEPTH];

	assign accept   = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;
	assign pos_x    = IW'(position);
	assign used_x   = IW'(used_q);
	assign top_x    = used_x - IW'(1);
	assign new_word = WORD_BITS'($unsigned(value));

	always_comb begin
		ctrl.op = iira_pkg::CELL_HOLD;
		ctrl.lo = pos_x;
		ctrl.hi = used_x;
		st      = iira_pkg::ST_OK;
		used_d  = used_q;
		rd_en   = 1'b0;
		rd_addr = pos_x;
		case (cmd)
			iira_pkg::CMD_PUSH: begin
				if (used_x >= DEPTH_X) begin
					st = iira_pkg::ST_FULL;
				end else begin
					ctrl.op = iira_pkg::CELL_PUT;
					ctrl.lo = used_x;
					used_d  = used_q + UW'(1);
				end
			end
			iira_pkg::CMD_INSERT: begin
				if (pos_x > used_x) begin
					st = iira_pkg::ST_RANGE;
				end else if (used_x >= DEPTH_X) begin
					st = iira_pkg::ST_FULL;
				end else begin
					ctrl.op = iira_pkg::CELL_OPEN;
					used_d  = used_q + UW'(1);
				end
			end
			iira_pkg::CMD_REMOVE: begin
				if (pos_x >= used_x) begin
					st = iira_pkg::ST_RANGE;
				end else begin
					ctrl.op = iira_pkg::CELL_CLOSE;
					ctrl.hi = top_x;
					used_d  = used_q - UW'(1);
				end
			end
			iira_pkg::CMD_POP: begin
				if (used_q == '0) begin
					st = iira_pkg::ST_EMPTY;
				end else begin
					rd_en   = 1'b1;
					rd_addr = top_x;
					used_d  = used_q - UW'(1);
				end
			end
			iira_pkg::CMD_READ: begin
				if (pos_x >= used_x) st = iira_pkg::ST_RANGE;
				else rd_en = 1'b1;
			end
			iira_pkg::CMD_WRITE: begin
				if (pos_x >= used_x) st = iira_pkg::ST_RANGE;
				else ctrl.op = iira_pkg::CELL_PUT;
			end
			iira_pkg::CMD_CLEAR: begin
				ctrl.op = iira_pkg::CELL_CLEAR;
				used_d  = '0;
			end
			default: begin
				st = iira_pkg::ST_OK;
			end
		endcase
		// hold the row unless a request is taken
		if (!accept) ctrl.op = iira_pkg::CELL_HOLD;
	end

	// rd_addr stays below the fill count whenever rd_en is set
	assign rd_word = cell_word[rd_addr[AW-1:0]];
	assign rd_out  = rd_en ? 32'($signed(rd_word)) : '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_BITS-1:0] left_w;
		logic [WORD_BITS-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_word[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_word[i+1];
		end
		iira_cell #(
			.WORD_BITS(WORD_BITS),
			.INDEX    (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.new_word  (new_word),
			.left_word (left_w),
			.right_word(right_w),
			.word      (cell_word[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				used_q      <= used_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_data_q <= rd_out;
			status_q    <= st;
			fill_q      <= 5'(used_d);
			is_empty_q  <= (used_d == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign status    = status_q;
	assign fill      = fill_q;
	assign is_empty  = is_empty_q;

endmodule

### src/iira_checker.sv
// Port-level checks for the indexed insert/remove array, bound to the top level.
// Depends on iira_pkg and indexed_insert_remove_array.
module iira_checker #(
	parameter int DEPTH = 16
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [2:0]         cmd,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] read_data,
	input logic [1:0]         status,
	input logic [4:0]         fill,
	input logic               is_empty
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(status)
			&& $stable(fill))
		else $error("result changed while stalled");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (fill == 5'd0)) || (DEPTH >= 32))
		else $error("empty flag disagrees with fill");

	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != 2'(iira_pkg::ST_OK)) |-> read_data == '0)
		else $error("failed request returned data");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (cmd == 3'(iira_pkg::CMD_CLEAR)) |=>
			out_valid && is_empty && (status == 2'(iira_pkg::ST_OK)))
		else $error("clear did not empty the array");

endmodule

bind indexed_insert_remove_array iira_checker #(.DEPTH(DEPTH)) u_iira_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.cmd      (cmd),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.read_data(read_data),
	.status   (status),
	.fill     (fill),
	.is_empty (is_empty)
);

### sim/testbench.sv
// Self-checking testbench for indexed_insert_remove_array.
// Queue-fed driver, pattern-stalled receiver, and a request predictor that checks each result.
// Depends on iira_pkg and the indexed_insert_remove_array RTL.
module testbench;

	localparam int DEPTH = 16;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 5;
	localparam logic [2:0] CMD_NONE = 3'd7;

	typedef struct {
		logic [2:0]         op;
		logic [4:0]         pos;
		logic signed [31:0] val;
		bit                 drain;
	} request_t;

	typedef struct {
		logic signed [31:0]         read_data;
		iira_pkg::status_t          status;
		logic [4:0]                 fill;
		logic                       is_empty;
	} result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [2:0]         cmd = CMD_NONE;
	logic [4:0]         position = '0;
	logic signed [31:0] value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] read_data;
	logic [1:0]         status;
	logic [4:0]         fill;
	logic               is_empty;

	request_t           pending_reqs[$];
	result_t            expected_results[$];
	logic signed [31:0] array_cells[DEPTH];
	int                 array_used = 0;
	int                 failures = 0;
	int                 req_total = 0;
	int                 req_count = 0;
	int                 idle_cycles = 0;
	bit                 req_taken = 1'b0;
	int                 burst_left = 0;
	int                 gap_left = 0;
	int unsigned        rx_tick = 0;
	int unsigned        rx_mode = 0;

	indexed_insert_remove_array #(
		.DEPTH(DEPTH),
		.WORD_BITS(32)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.position(position),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.status(status),
		.fill(fill),
		.is_empty(is_empty)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic add_request(input logic [2:0] op, input logic [4:0] pos,
			input logic signed [31:0] val);
		request_t r;
		r.op = op;
		r.pos = pos;
		r.val = val;
		r.drain = 1'b0;
		pending_reqs.insert(pending_reqs.size(), r);
		req_total++;
	endtask

	task automatic add_drain();
		request_t r;
		r.op = CMD_NONE;
		r.pos = '0;
		r.val = '0;
		r.drain = 1'b1;
		pending_reqs.insert(pending_reqs.size(), r);
	endtask

	task automatic predict_array(input logic [2:0] op, input logic [4:0] pos,
			input logic signed [31:0] val);
		result_t r;
		int i;
		int p;
		p = int'(pos);
		r.read_data = '0;
		r.status = iira_pkg::ST_OK;
		case (op)
		iira_pkg::CMD_PUSH: begin
			if (array_used >= DEPTH) begin
				r.status = iira_pkg::ST_FULL;
			end else begin
				array_cells[array_used] = val;
				array_used++;
			end
		end
		iira_pkg::CMD_INSERT: begin
			// index check wins over full
			if (p > array_used) begin
				r.status = iira_pkg::ST_RANGE;
			end else if (array_used >= DEPTH) begin
				r.status = iira_pkg::ST_FULL;
			end else begin
				for (i = array_used; i > p; i--)
					array_cells[i] = array_cells[i-1];
				array_cells[p] = val;
				array_used++;
			end
		end
		iira_pkg::CMD_REMOVE: begin
			if (p >= array_used) begin
				r.status = iira_pkg::ST_RANGE;
			end else begin
				for (i = p; i + 1 < array_used; i++)
					array_cells[i] = array_cells[i+1];
				// zero the freed top slot
				array_cells[array_used-1] = '0;
				array_used--;
			end
		end
		iira_pkg::CMD_POP: begin
			if (array_used == 0) begin
				r.status = iira_pkg::ST_EMPTY;
			end else begin
				r.read_data = array_cells[array_used-1];
				array_used--;
			end
		end
		iira_pkg::CMD_READ: begin
			if (p >= array_used)
				r.status = iira_pkg::ST_RANGE;
			else
				r.read_data = array_cells[p];
		end
		iira_pkg::CMD_WRITE: begin
			if (p >= array_used)
				r.status = iira_pkg::ST_RANGE;
			else
				array_cells[p] = val;
		end
		iira_pkg::CMD_CLEAR: begin
			for (i = 0; i < DEPTH; i++)
				array_cells[i] = '0;
			array_used = 0;
		end
		default: begin
		end
		endcase
		r.fill = 5'(array_used);
		r.is_empty = (array_used == 0);
		expected_results.insert(expected_results.size(), r);
	endtask

	task automatic check_result(input result_t exp);
		if (read_data !== exp.read_data) begin
			$display("%0t: read_data expected %0d actual %0d", $time, exp.read_data, read_data);
			failures++;
		end
		if (status !== exp.status) begin
			$display("%0t: status expected %0d actual %0d", $time, exp.status, status);
			failures++;
		end
		if (fill !== exp.fill) begin
			$display("%0t: fill expected %0d actual %0d", $time, exp.fill, fill);
			failures++;
		end
		if (is_empty !== exp.is_empty) begin
			$display("%0t: is_empty expected %0d actual %0d", $time, exp.is_empty, is_empty);
			failures++;
		end
	endtask

	// Driver: bursts of requests with random gaps; a drain marker holds off until idle.
	always @(negedge clk) begin : drive_requests
		request_t r;
		if (arst_n && !(in_valid && !req_taken)) begin
			if (pending_reqs.size() > 0 && pending_reqs[0].drain && expected_results.size() == 0)
				r = pending_reqs.pop_front();
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() > 0 && !pending_reqs[0].drain) begin
				r = pending_reqs.pop_front();
				in_valid <= 1'b1;
				cmd <= r.op;
				position <= r.pos;
				value <= r.val;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = int'($urandom_range(0, 20));
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: periodically pick one of four stall patterns at random.
	always @(negedge clk) begin
		rx_tick++;
		if (rx_tick % 64 == 0)
			rx_mode = $urandom_range(0, 3);
		case (rx_mode)
		0: out_ready <= 1'b1;
		1: out_ready <= (rx_tick % 4 != 0);
		2: out_ready <= 1'($urandom_range(0, 1));
		default: out_ready <= (rx_tick % 16 >= 10);
		endcase
	end

	always @(posedge clk) begin
		req_taken = arst_n && in_valid && in_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with no request outstanding", $time);
					failures++;
				end else begin
					check_result(expected_results.pop_front());
				end
			end
			if (req_taken) begin
				predict_array(cmd, position, value);
				req_count++;
			end
			if (req_taken || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int k;
		int roll;
		int phase_left;
		bit grow;
		logic [2:0] op;
		logic [4:0] pos;
		logic signed [31:0] val;
		foreach (array_cells[i])
			array_cells[i] = '0;

		// empty-array corner cases
		add_request(iira_pkg::CMD_CLEAR, 5'd0, 32'sd0);
		add_request(iira_pkg::CMD_POP, 5'd0, 32'sd0);
		add_request(iira_pkg::CMD_REMOVE, 5'd0, 32'sd0);
		add_request(iira_pkg::CMD_READ, 5'd0, 32'sd0);
		add_request(iira_pkg::CMD_INSERT, 5'd1, 32'sd5);
		add_request(iira_pkg::CMD_PUSH, 5'd31, 32'sh7fffffff);
		add_request(iira_pkg::CMD_PUSH, 5'd0, 32'sh80000000);
		add_request(iira_pkg::CMD_INSERT, 5'd0, -32'sd1);
		add_request(iira_pkg::CMD_INSERT, 5'd3, 32'sd0);
		add_request(iira_pkg::CMD_WRITE, 5'd31, 32'sd9);
		add_request(iira_pkg::CMD_WRITE, 5'd2, 32'sh5a5a5a5a);
		add_request(iira_pkg::CMD_READ, 5'd0, 32'sd0);
		add_request(iira_pkg::CMD_READ, 5'd3, 32'sd0);
		add_request(iira_pkg::CMD_READ, 5'd4, 32'sd0);
		add_request(iira_pkg::CMD_REMOVE, 5'd1, 32'sd0);
		add_request(iira_pkg::CMD_POP, 5'd0, 32'sd0);
		add_request(CMD_NONE, 5'd31, -32'sd1);
		add_request(iira_pkg::CMD_READ, 5'd1, 32'sd0);
		add_request(iira_pkg::CMD_CLEAR, 5'd0, 32'sd0);
		add_request(iira_pkg::CMD_READ, 5'd0, 32'sd0);
		add_drain();

		// alternate growing and shrinking phases so the array hits full and empty often
		grow = 1'b0;
		phase_left = 0;
		for (k = 0; k < 600; k++) begin
			if (phase_left == 0) begin
				grow = !grow;
				phase_left = int'($urandom_range(10, 40));
			end
			phase_left--;
			roll = int'($urandom_range(0, 99));
			if (grow) begin
				if (roll < 35) op = iira_pkg::CMD_PUSH;
				else if (roll < 65) op = iira_pkg::CMD_INSERT;
				else if (roll < 70) op = iira_pkg::CMD_REMOVE;
				else if (roll < 75) op = iira_pkg::CMD_POP;
				else if (roll < 85) op = iira_pkg::CMD_READ;
				else if (roll < 95) op = iira_pkg::CMD_WRITE;
				else if (roll < 96) op = iira_pkg::CMD_CLEAR;
				else op = CMD_NONE;
			end else begin
				if (roll < 5) op = iira_pkg::CMD_PUSH;
				else if (roll < 10) op = iira_pkg::CMD_INSERT;
				else if (roll < 40) op = iira_pkg::CMD_REMOVE;
				else if (roll < 70) op = iira_pkg::CMD_POP;
				else if (roll < 82) op = iira_pkg::CMD_READ;
				else if (roll < 94) op = iira_pkg::CMD_WRITE;
				else if (roll < 96) op = iira_pkg::CMD_CLEAR;
				else op = CMD_NONE;
			end
			if ($urandom_range(0, 99) < 85)
				pos = 5'($urandom_range(0, 17));
			else
				pos = 5'($urandom_range(0, 31));
			case ($urandom_range(0, 19))
			0: val = 32'sh80000000;
			1: val = 32'sh7fffffff;
			2: val = -32'sd1;
			3: val = 32'sd0;
			default: val = $urandom;
			endcase
			add_request(op, pos, val);
			if (k == 300)
				add_drain();
		end

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		while (req_count < req_total || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
